@@ src/lqr_pkg.sv @@
// Package for the LQR steering gain block: constants, types and fixed-point helpers.
// Used by lqr_alu, lqr_div and lqr_riccati_gain_steer; depends on nothing.
package lqr_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int ITER_LIMIT = 1024;
  localparam int CAP_W      = 11;
  localparam int CNT_W      = $clog2(ITER_LIMIT + 1);

  localparam logic [31:0] THR_0_75 = 32'((64'd3 << FRAC_BITS) / 4);
  localparam logic [31:0] THR_1_2  = 32'(((64'd12 << FRAC_BITS) + 5) / 10);
  localparam logic [31:0] THR_1_75 = 32'((64'd7 << FRAC_BITS) / 4);
  localparam logic [31:0] THR_2    = 32'(64'd2 << FRAC_BITS);
  localparam logic [31:0] THR_2_5  = 32'((64'd5 << FRAC_BITS) / 2);
  localparam logic [31:0] THR_3    = 32'(64'd3 << FRAC_BITS);
  localparam logic [31:0] THR_3_5  = 32'((64'd7 << FRAC_BITS) / 2);

  // Register indexes.
  localparam logic [2:0] REG_Q0  = 3'd0;
  localparam logic [2:0] REG_Q1S = 3'd1;
  localparam logic [2:0] REG_R0S = 3'd2;
  localparam logic [2:0] REG_R1  = 3'd3;
  localparam logic [2:0] REG_DT  = 3'd4;
  localparam logic [2:0] REG_WB  = 3'd5;
  localparam logic [2:0] REG_TOL = 3'd6;
  localparam logic [2:0] REG_CAP = 3'd7;

  // ALU operation codes.
  typedef enum logic [2:0] {
    OP_MUL, OP_ADD, OP_SUB, OP_NEG, OP_ABS, OP_MAX
  } alu_op_e;

  typedef struct packed {
    logic        start;
    logic        neg;
    logic [31:0] num_mag;
    logic [31:0] den_mag;
    logic        den_zero;
    logic        num_zero;
    logic        num_pos;
  } div_req_t;

  function automatic logic signed [31:0] clamp32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) return 32'sh7fffffff;
    if (x < -66'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic [31:0] band_weight(input logic [2:0] band, input logic is_q);
    logic [7:0] w;
    case (band)
      3'd0: w = is_q ? 8'd135 : 8'd70;
      3'd1: w = is_q ? 8'd115 : 8'd80;
      3'd2: w = is_q ? 8'd125 : 8'd80;
      3'd3: w = is_q ? 8'd120 : 8'd95;
      3'd4: w = is_q ? 8'd110 : 8'd120;
      3'd5: w = is_q ? 8'd95  : 8'd145;
      3'd6: w = is_q ? 8'd75  : 8'd175;
      default: w = is_q ? 8'd60 : 8'd200;
    endcase
    return clamp32(66'(w) << FRAC_BITS);
  endfunction

endpackage

@@ src/lqr_if.sv @@
// Valid/ready channel interfaces for the LQR steering block.
// Depends on nothing.
interface lqr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] speed;
  logic [31:0] error_first;
  logic [31:0] error_second;
  modport source (output valid, speed, error_first, error_second, input ready);
  modport sink   (input valid, speed, error_first, error_second, output ready);
endinterface

interface lqr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] steer_command;
  logic [31:0] gain_first;
  logic [31:0] gain_second;
  logic        converged;
  modport source (output valid, steer_command, gain_first, gain_second, converged,
                  input ready);
  modport sink   (input valid, steer_command, gain_first, gain_second, converged,
                  output ready);
endinterface

interface lqr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/lqr_alu.sv @@
// Shared fixed-point ALU: one saturating op per cycle, result registered.
// Depends on lqr_pkg.
module lqr_alu import lqr_pkg::*; (
  input  logic               clk_i,
  input  alu_op_e            op_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [31:0] y_o
);
  logic signed [63:0] prod;
  logic        [63:0] pm;
  logic        [47:0] rnd;
  logic signed [31:0] y_d, y_q;

  assign prod = a_i * b_i;
  assign pm   = prod[63] ? 64'(-prod) : 64'(prod);
  assign rnd  = 48'((pm + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);

  always_comb begin
    case (op_i)
      OP_MUL: y_d = prod[63] ? clamp32(-66'($signed({1'b0, rnd})))
                             : clamp32(66'($signed({1'b0, rnd})));
      OP_ADD: y_d = clamp32(66'(a_i) + 66'(b_i));
      OP_SUB: y_d = clamp32(66'(a_i) - 66'(b_i));
      OP_NEG: y_d = clamp32(-66'(a_i));
      OP_ABS: y_d = a_i[31] ? clamp32(-66'(a_i)) : a_i;
      OP_MAX: y_d = (a_i > b_i) ? a_i : b_i;
      default: y_d = a_i;
    endcase
  end

  always_ff @(posedge clk_i) y_q <= y_d;
  assign y_o = y_q;
endmodule

@@ src/lqr_div.sv @@
// Radix-2 restoring divider for rounded fixed-point quotients.
// Depends on lqr_pkg.
module lqr_div import lqr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  div_req_t           req_i,
  output logic               busy_o,
  output logic signed [31:0] q_o
);
  localparam int NW = 32 + FRAC_BITS;
  logic [NW-1:0] num_q, num_d, quo_q, quo_d;
  logic [32:0]   rem_q, rem_d, trial;
  logic [5:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d, neg_q;
  logic [31:0]   den_q;
  logic [NW:0]   qr;
  logic signed [31:0] res_q, res_d;
  logic          done;

  assign trial = {rem_q[31:0], num_q[NW-1]};
  assign done  = busy_q && (cnt_q == 6'(NW - 1));

  always_comb begin
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    res_d  = res_q;
    qr     = '0;
    if (req_i.start) begin
      busy_d = 1'b1;
      num_d  = NW'({req_i.num_mag, {FRAC_BITS{1'b0}}}) + NW'(req_i.den_mag >> 1);
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = '0;
      if (req_i.den_zero) begin
        busy_d = 1'b0;
        res_d  = req_i.num_zero ? 32'sd0 : (req_i.num_pos ? 32'sh7fffffff : 32'sh80000000);
      end
    end else if (busy_q) begin
      num_d = num_q << 1;
      cnt_d = cnt_q + 6'd1;
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      if (done) begin
        busy_d = 1'b0;
        qr = {1'b0, quo_d};
        res_d = neg_q ? clamp32(-66'($signed({1'b0, qr}))) : clamp32(66'($signed({1'b0, qr})));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    res_q <= res_d;
    if (req_i.start) begin
      den_q <= req_i.den_mag;
      neg_q <= req_i.neg;
    end
  end

  assign busy_o = busy_q;
  assign q_o    = res_q;
endmodule

@@ src/lqr_riccati_gain_steer.sv @@
// LQR steering gain: one shared ALU and one divider under a microcoded sequencer.
// Each Riccati step runs two divides, and these dominate its time.
// One item at a time; ready is low from acceptance until the result word is taken.
// Asynchronous active-low reset restores register defaults and idles the sequencer.
// Depends on lqr_pkg, lqr_if, lqr_alu and lqr_div.
module lqr_riccati_gain_steer import lqr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  lqr_cfg_if.sink   cfg,
  lqr_in_if.sink    in_ch,
  lqr_out_if.source out_ch
);
  // Scratch registers in the register file.
  localparam logic [4:0] R_A = 5'd0, R_B = 5'd1, R_P0 = 5'd2, R_P1 = 5'd3, R_P2 = 5'd4,
    R_P3 = 5'd5, R_Q0 = 5'd6, R_Q1 = 5'd7, R_R0 = 5'd8, R_T0 = 5'd9, R_T1 = 5'd10,
    R_X = 5'd11, R_Y = 5'd12, R_S0 = 5'd13, R_D0 = 5'd14, R_D1 = 5'd15, R_C0 = 5'd16,
    R_C1 = 5'd17, R_N0 = 5'd18, R_N1 = 5'd19, R_N2 = 5'd20, R_N3 = 5'd21, R_MX = 5'd22,
    R_E0 = 5'd23, R_E1 = 5'd24, R_V = 5'd25, R_DT = 5'd26, R_WB = 5'd27, R_K0 = 5'd28,
    R_K1 = 5'd29, R_Z = 5'd30;

  localparam logic [1:0] S_IDLE = 2'd0, S_RUN = 2'd1, S_OUT = 2'd2;

  typedef struct packed {
    logic [1:0] kind;  // 0 alu, 1 div, 2 loop test, 3 finish
    alu_op_e    op;
    logic [4:0] ra;
    logic [4:0] rb;
    logic [4:0] rd;
  } uop_t;
  localparam logic [1:0] K_ALU = 2'd0, K_DIV = 2'd1, K_TEST = 2'd2, K_END = 2'd3;
  localparam logic [6:0] PC_LOOP = 7'd3, PC_GAIN = 7'd38;

  function automatic uop_t rom(input logic [6:0] pc);
    uop_t u;
    u = '{K_ALU, OP_MUL, R_Z, R_Z, R_Z};
    case (pc)
      7'd0:  u = '{K_ALU, OP_MUL, R_V, R_DT, R_A};
      7'd1:  u = '{K_DIV, OP_MUL, R_A, R_WB, R_B};
      7'd2:  u = '{K_TEST, OP_MUL, R_Z, R_Z, R_Z};
      7'd3:  u = '{K_ALU, OP_MUL, R_A, R_P1, R_X};
      7'd4:  u = '{K_ALU, OP_ADD, R_P0, R_X, R_T0};
      7'd5:  u = '{K_ALU, OP_MUL, R_A, R_P3, R_X};
      7'd6:  u = '{K_ALU, OP_ADD, R_P2, R_X, R_T1};
      7'd7:  u = '{K_ALU, OP_MUL, R_A, R_T1, R_X};
      7'd8:  u = '{K_ALU, OP_ADD, R_T0, R_X, R_N0};
      7'd9:  u = '{K_ALU, OP_MUL, R_A, R_P3, R_X};
      7'd10: u = '{K_ALU, OP_ADD, R_P1, R_X, R_N1};
      7'd11: u = '{K_ALU, OP_MUL, R_A, R_P2, R_X};
      7'd12: u = '{K_ALU, OP_ADD, R_P0, R_X, R_X};
      7'd13: u = '{K_ALU, OP_MUL, R_B, R_X, R_C0};
      7'd14: u = '{K_ALU, OP_MUL, R_B, R_P2, R_C1};
      7'd15: u = '{K_ALU, OP_MUL, R_B, R_P0, R_X};
      7'd16: u = '{K_ALU, OP_MUL, R_B, R_X, R_X};
      7'd17: u = '{K_ALU, OP_ADD, R_R0, R_X, R_S0};
      7'd18: u = '{K_ALU, OP_MUL, R_B, R_T0, R_Y};
      7'd19: u = '{K_DIV, OP_MUL, R_Y, R_S0, R_D0};
      7'd20: u = '{K_ALU, OP_MUL, R_B, R_P1, R_Y};
      7'd21: u = '{K_DIV, OP_MUL, R_Y, R_S0, R_D1};
      7'd22: u = '{K_ALU, OP_MUL, R_C0, R_D0, R_X};
      7'd23: u = '{K_ALU, OP_SUB, R_N0, R_X, R_X};
      7'd24: u = '{K_ALU, OP_ADD, R_X, R_Q0, R_N0};
      7'd25: u = '{K_ALU, OP_MUL, R_C0, R_D1, R_X};
      7'd26: u = '{K_ALU, OP_SUB, R_N1, R_X, R_N1};
      7'd27: u = '{K_ALU, OP_MUL, R_C1, R_D0, R_X};
      7'd28: u = '{K_ALU, OP_SUB, R_T1, R_X, R_N2};
      7'd29: u = '{K_ALU, OP_MUL, R_C1, R_D1, R_X};
      7'd30: u = '{K_ALU, OP_SUB, R_P3, R_X, R_X};
      7'd31: u = '{K_ALU, OP_ADD, R_X, R_Q1, R_N3};
      7'd32: u = '{K_ALU, OP_SUB, R_N0, R_P0, R_MX};
      7'd33: u = '{K_ALU, OP_SUB, R_N1, R_P1, R_X};
      7'd34: u = '{K_ALU, OP_MAX, R_MX, R_X, R_MX};
      7'd35: u = '{K_ALU, OP_SUB, R_N2, R_P2, R_X};
      7'd36: u = '{K_ALU, OP_MAX, R_MX, R_X, R_MX};
      7'd37: u = '{K_ALU, OP_SUB, R_N3, R_P3, R_X};
      7'd38: u = '{K_ALU, OP_MAX, R_MX, R_X, R_MX};
      7'd39: u = '{K_ALU, OP_ABS, R_MX, R_Z, R_MX};
      7'd40: u = '{K_TEST, OP_MUL, R_Z, R_Z, R_Z};
      // Gain row from the final P.
      7'd41: u = '{K_ALU, OP_MUL, R_B, R_P0, R_X};
      7'd42: u = '{K_ALU, OP_MUL, R_B, R_X, R_X};
      7'd43: u = '{K_ALU, OP_ADD, R_R0, R_X, R_S0};
      7'd44: u = '{K_ALU, OP_MUL, R_A, R_P1, R_X};
      7'd45: u = '{K_ALU, OP_ADD, R_P0, R_X, R_T0};
      7'd46: u = '{K_ALU, OP_MUL, R_B, R_T0, R_Y};
      7'd47: u = '{K_DIV, OP_MUL, R_Y, R_S0, R_K0};
      7'd48: u = '{K_ALU, OP_MUL, R_B, R_P1, R_Y};
      7'd49: u = '{K_DIV, OP_MUL, R_Y, R_S0, R_K1};
      7'd50: u = '{K_ALU, OP_MUL, R_K0, R_E0, R_X};
      7'd51: u = '{K_ALU, OP_MUL, R_K1, R_E1, R_Y};
      7'd52: u = '{K_ALU, OP_ADD, R_X, R_Y, R_X};
      7'd53: u = '{K_ALU, OP_NEG, R_X, R_Z, R_X};
      7'd54: u = '{K_END, OP_MUL, R_Z, R_Z, R_Z};
      default: u = '{K_END, OP_MUL, R_Z, R_Z, R_Z};
    endcase
    return u;
  endfunction

  logic [30:0] q0_q, q1s_q, r0s_q, dt_q, wb_q, tol_q, r1_q;
  logic [CAP_W-1:0] cap_q;
  logic signed [31:0] rf_q [32];
  logic [1:0] state_q, state_d;
  logic [6:0] pc_q;
  logic [1:0] ph_q;  // 0 issue, 1 write back, 2 divider wait
  logic [CNT_W-1:0] n_q;
  logic conv_q;
  uop_t u;
  alu_op_e op;
  logic signed [31:0] ra_v, rb_v, alu_y, div_y;
  div_req_t dreq;
  logic div_busy;
  logic [CNT_W-1:0] cap_eff;
  logic [31:0] av;
  logic [2:0] band;
  logic loop_go, diff_ok;
  logic in_acc;

  assign u    = rom(pc_q);
  assign op   = u.op;
  assign ra_v = rf_q[u.ra];
  assign rb_v = rf_q[u.rb];

  lqr_alu u_alu (.clk_i, .op_i(op), .a_i(ra_v), .b_i(rb_v), .y_o(alu_y));

  always_comb begin
    dreq.start    = (state_q == S_RUN) && (u.kind == K_DIV) && (ph_q == 2'd0);
    dreq.neg      = ra_v[31] != rb_v[31];
    dreq.num_mag  = ra_v[31] ? 32'(-ra_v) : 32'(ra_v);
    dreq.den_mag  = rb_v[31] ? 32'(-rb_v) : 32'(rb_v);
    dreq.den_zero = rb_v == 32'sd0;
    dreq.num_zero = ra_v == 32'sd0;
    dreq.num_pos  = !ra_v[31];
  end

  lqr_div u_div (.clk_i, .rst_ni, .req_i(dreq), .busy_o(div_busy), .q_o(div_y));

  assign cap_eff = (cap_q > CAP_W'(ITER_LIMIT)) ? CNT_W'(ITER_LIMIT) : CNT_W'(cap_q);
  assign diff_ok = rf_q[R_MX] <= $signed({1'b0, tol_q});
  // The first test comes before any step, so the change measure is not yet known.
  assign loop_go = (n_q < cap_eff) && ((pc_q == 7'd2) || !diff_ok);

  assign av = in_ch.speed[31] ? 32'(-$signed(in_ch.speed)) : in_ch.speed;
  always_comb begin
    if (av < THR_0_75) band = 3'd0;
    else if (av < THR_1_2) band = 3'd1;
    else if (av < THR_1_75) band = 3'd2;
    else if (av < THR_2) band = 3'd3;
    else if (av < THR_2_5) band = 3'd4;
    else if (av < THR_3) band = 3'd5;
    else if (av < THR_3_5) band = 3'd6;
    else band = 3'd7;
  end

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = state_q == S_IDLE;
  assign cfg.ready    = 1'b1;
  assign out_ch.valid = state_q == S_OUT;
  assign out_ch.steer_command = rf_q[R_X];
  assign out_ch.gain_first    = rf_q[R_K0];
  assign out_ch.gain_second   = rf_q[R_K1];
  assign out_ch.converged     = conv_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_RUN;
      S_RUN:  if (u.kind == K_END) state_d = S_OUT;
      S_OUT:  if (out_ch.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q0_q <= 31'd65536; q1s_q <= 31'd65536; r0s_q <= 31'd65536; r1_q <= 31'd65536;
      dt_q <= 31'd1311; wb_q <= 31'd65536; tol_q <= 31'd7; cap_q <= CAP_W'(100);
      state_q <= S_IDLE;
      pc_q <= '0;
      ph_q <= '0;
      n_q <= '0;
      conv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_Q0:  q0_q  <= cfg.data[30:0];
          REG_Q1S: q1s_q <= cfg.data[30:0];
          REG_R0S: r0s_q <= cfg.data[30:0];
          REG_R1:  r1_q  <= cfg.data[30:0];
          REG_DT:  dt_q  <= cfg.data[30:0];
          REG_WB:  wb_q  <= cfg.data[30:0];
          REG_TOL: tol_q <= cfg.data[30:0];
          REG_CAP: cap_q <= cfg.data[CAP_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        pc_q <= '0;
        ph_q <= '0;
        n_q  <= '0;
        conv_q <= 1'b0;
      end else if (state_q == S_RUN) begin
        case (u.kind)
          K_ALU: begin
            ph_q <= ph_q ^ 2'd1;
            if (ph_q == 2'd1) pc_q <= pc_q + 7'd1;
          end
          K_DIV: begin
            if (ph_q == 2'd0) ph_q <= 2'd2;
            else if (!div_busy) begin
              ph_q <= 2'd0;
              pc_q <= pc_q + 7'd1;
            end
          end
          K_TEST: begin
            if (loop_go) begin
              pc_q <= PC_LOOP;
              n_q  <= n_q + CNT_W'(1);
            end else begin
              pc_q <= PC_GAIN + 7'd3;
              conv_q <= (pc_q != 7'd2) && diff_ok;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rf_q[R_Z]  <= '0;
      rf_q[R_V]  <= in_ch.speed;
      rf_q[R_E0] <= in_ch.error_first;
      rf_q[R_E1] <= in_ch.error_second;
      rf_q[R_DT] <= {1'b0, dt_q};
      rf_q[R_WB] <= {1'b0, wb_q};
      rf_q[R_Q0] <= {1'b0, q0_q};
      rf_q[R_P0] <= {1'b0, q0_q};
      rf_q[R_P1] <= '0;
      rf_q[R_P2] <= '0;
      rf_q[R_MX] <= {1'b0, r1_q} & 32'sd0;
      if (in_ch.speed == 32'd0) begin
        rf_q[R_Q1] <= {1'b0, q1s_q};
        rf_q[R_P3] <= {1'b0, q1s_q};
        rf_q[R_R0] <= {1'b0, r0s_q};
      end else begin
        rf_q[R_Q1] <= band_weight(band, 1'b1);
        rf_q[R_P3] <= band_weight(band, 1'b1);
        rf_q[R_R0] <= band_weight(band, 1'b0);
      end
    end else if (state_q == S_RUN) begin
      if (u.kind == K_ALU && ph_q == 2'd1) rf_q[u.rd] <= alu_y;
      if (u.kind == K_DIV && ph_q == 2'd2 && !div_busy) rf_q[u.rd] <= div_y;
      // Commit the new P once the change measure is taken.
      if (u.kind == K_ALU && ph_q == 2'd1 && pc_q == 7'd39) begin
        rf_q[R_P0] <= rf_q[R_N0];
        rf_q[R_P1] <= rf_q[R_N1];
        rf_q[R_P2] <= rf_q[R_N2];
        rf_q[R_P3] <= rf_q[R_N3];
      end
    end
  end
endmodule

@@ src/lqr_checker.sv @@
// Port-level checker for the LQR steering block, bound to the top level.
// Depends on lqr_if through the bound instance's ports.
module lqr_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic [31:0] out_cmd_i
);
  // A word is accepted only when no result is pending.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i)) else $error("input ready while result pending");
  // After an accepted word the block stops taking input.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i) else $error("ready after accept");
  // A pending result holds until taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_cmd_i)))
    else $error("result dropped");
  // A result rises only while input ready is low.
  a_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !in_ready_i) else $error("spurious result");
endmodule

bind lqr_riccati_gain_steer lqr_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_ch.valid), .in_ready_i(in_ch.ready),
  .out_valid_i(out_ch.valid), .out_ready_i(out_ch.ready),
  .out_cmd_i(out_ch.steer_command));
